// File: hw/rtl/sgi_pkg.sv
package sgi_pkg;

    // configuration port geometry
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;

    // register word index, taken from paddr[2]
    localparam logic REG_PARALLEL_THRESHOLD = 1'b0;

    // parallel threshold register, unsigned Q24.8
    localparam int THR_WIDTH = 32;
    localparam logic [THR_WIDTH-1:0] THR_RESET = '0;

endpackage

// File: hw/rtl/segment_intersection_unit.sv
// 2D segment intersection: edge A-B against query segment S-E, signed Q12.4.
// input channel: i_valid / o_stall, a transaction carries the eight endpoint
// coordinates; output channel: o_valid / i_stall, a transaction carries hit
// and the intersection point (point is zero when there is no hit).
// a transaction completes at a clock edge where valid is high and stall low.
// throughput: one transaction per cycle in both directions while the receiver does not stall.
// pipeline stages from input to output: three for differences, products
// and cross terms, two for the parallel/range tests and the dividend
// products, one restoring divider stage per quotient bit, one output
// register. The divider sets the depth.
// when the receiver stalls a valid result, the whole pipeline holds and
// o_stall is raised, so nothing is dropped or repeated.
// reset (synchronous, active low) empties the pipeline and clears the
// parallel threshold register to zero.
// apb register 0 (byte address 0): parallel threshold, unsigned Q24.8;
// a |denominator| at or below it is treated as parallel. write only while idle.
module segment_intersection_unit
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_edge_ax,
    input  logic signed [COORD_WIDTH-1:0] i_edge_ay,
    input  logic signed [COORD_WIDTH-1:0] i_edge_bx,
    input  logic signed [COORD_WIDTH-1:0] i_edge_by,
    input  logic signed [COORD_WIDTH-1:0] i_line_sx,
    input  logic signed [COORD_WIDTH-1:0] i_line_sy,
    input  logic signed [COORD_WIDTH-1:0] i_line_ex,
    input  logic signed [COORD_WIDTH-1:0] i_line_ey,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [APB_DATA_WIDTH-1:0]     pwdata,
    output logic [APB_DATA_WIDTH-1:0]     prdata,
    output logic                          pready
);

    localparam int W = COORD_WIDTH;

    // configuration register
    logic [THR_WIDTH-1:0] r_threshold;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_PARALLEL_THRESHOLD) begin
            r_threshold <= pwdata[THR_WIDTH-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PARALLEL_THRESHOLD) ? r_threshold : '0;

    // pipeline advance: hold everything while a result waits on a stall
    logic r_out_valid;
    logic en;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // cross products
    logic                  c_valid;
    logic signed [W-1:0]   c_ax, c_ay;
    logic signed [W:0]     c_dx, c_dy;
    logic signed [2*W+2:0] c_den, c_ns, c_nt;

    sgi_cross #(.W(W)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ax    (i_edge_ax),
        .i_ay    (i_edge_ay),
        .i_bx    (i_edge_bx),
        .i_by    (i_edge_by),
        .i_sx    (i_line_sx),
        .i_sy    (i_line_sy),
        .i_ex    (i_line_ex),
        .i_ey    (i_line_ey),
        .o_valid (c_valid),
        .o_ax    (c_ax),
        .o_ay    (c_ay),
        .o_dx    (c_dx),
        .o_dy    (c_dy),
        .o_den   (c_den),
        .o_ns    (c_ns),
        .o_nt    (c_nt)
    );

    // hit decision and dividends
    logic                k_valid, k_hit, k_sx, k_sy;
    logic signed [W-1:0] k_ax, k_ay;
    logic [2*W:0]        k_den;
    logic [3*W:0]        k_mx, k_my;

    sgi_classify #(.W(W)) u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_threshold (r_threshold),
        .i_valid     (c_valid),
        .i_ax        (c_ax),
        .i_ay        (c_ay),
        .i_dx        (c_dx),
        .i_dy        (c_dy),
        .i_den       (c_den),
        .i_ns        (c_ns),
        .i_nt        (c_nt),
        .o_valid     (k_valid),
        .o_hit       (k_hit),
        .o_ax        (k_ax),
        .o_ay        (k_ay),
        .o_sx        (k_sx),
        .o_sy        (k_sy),
        .o_den       (k_den),
        .o_mx        (k_mx),
        .o_my        (k_my)
    );

    // pipelined divider
    logic                d_valid, d_hit, d_sx, d_sy;
    logic signed [W-1:0] d_ax, d_ay;
    logic [W-1:0]        d_qx, d_qy;

    sgi_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (k_valid),
        .i_hit   (k_hit),
        .i_ax    (k_ax),
        .i_ay    (k_ay),
        .i_sx    (k_sx),
        .i_sy    (k_sy),
        .i_den   (k_den),
        .i_mx    (k_mx),
        .i_my    (k_my),
        .o_valid (d_valid),
        .o_hit   (d_hit),
        .o_ax    (d_ax),
        .o_ay    (d_ay),
        .o_sx    (d_sx),
        .o_sy    (d_sy),
        .o_qx    (d_qx),
        .o_qy    (d_qy)
    );

    // apply quotient sign and add the edge start point
    logic signed [W+1:0] qx_ext, qy_ext, sum_x, sum_y;
    logic signed [W-1:0] n_point_x, n_point_y;

    always_comb begin
        qx_ext    = $signed({2'b00, d_qx});
        qy_ext    = $signed({2'b00, d_qy});
        sum_x     = (W+2)'(d_ax) + (d_sx ? -qx_ext : qx_ext);
        sum_y     = (W+2)'(d_ay) + (d_sy ? -qy_ext : qy_ext);
        n_point_x = d_hit ? sum_x[W-1:0] : '0;
        n_point_y = d_hit ? sum_y[W-1:0] : '0;
    end

    // output register
    logic                r_hit;
    logic signed [W-1:0] r_point_x, r_point_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit     <= d_hit;
            r_point_x <= n_point_x;
            r_point_y <= n_point_y;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_hit     = r_hit;
    assign o_point_x = r_point_x;
    assign o_point_y = r_point_y;

endmodule

// File: hw/rtl/sgi_cross.sv
module sgi_cross #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_ax,
    input  logic signed [W-1:0]   i_ay,
    input  logic signed [W-1:0]   i_bx,
    input  logic signed [W-1:0]   i_by,
    input  logic signed [W-1:0]   i_sx,
    input  logic signed [W-1:0]   i_sy,
    input  logic signed [W-1:0]   i_ex,
    input  logic signed [W-1:0]   i_ey,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_ax,
    output logic signed [W-1:0]   o_ay,
    output logic signed [W:0]     o_dx,
    output logic signed [W:0]     o_dy,
    output logic signed [2*W+2:0] o_den,
    output logic signed [2*W+2:0] o_ns,
    output logic signed [2*W+2:0] o_nt
);

    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int CW = 2 * W + 3;

    // stage 1: direction vectors and the offset from S to A
    logic                 r_s1_valid;
    logic signed [W-1:0]  r_s1_ax, r_s1_ay;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy, r_s1_lx, r_s1_ly, r_s1_kx, r_s1_ky;
    logic signed [DW-1:0] n_s1_dx, n_s1_dy, n_s1_lx, n_s1_ly, n_s1_kx, n_s1_ky;

    always_comb begin
        n_s1_dx = DW'(i_bx) - DW'(i_ax);
        n_s1_dy = DW'(i_by) - DW'(i_ay);
        n_s1_lx = DW'(i_ex) - DW'(i_sx);
        n_s1_ly = DW'(i_ey) - DW'(i_sy);
        n_s1_kx = DW'(i_ax) - DW'(i_sx);
        n_s1_ky = DW'(i_ay) - DW'(i_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ax <= i_ax;
            r_s1_ay <= i_ay;
            r_s1_dx <= n_s1_dx;
            r_s1_dy <= n_s1_dy;
            r_s1_lx <= n_s1_lx;
            r_s1_ly <= n_s1_ly;
            r_s1_kx <= n_s1_kx;
            r_s1_ky <= n_s1_ky;
        end
    end

    // stage 2: the six cross-product terms
    logic                 r_s2_valid;
    logic signed [W-1:0]  r_s2_ax, r_s2_ay;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy;
    logic signed [PW-1:0] r_s2_lx_dy, r_s2_ly_dx, r_s2_kx_ly;
    logic signed [PW-1:0] r_s2_ky_lx, r_s2_kx_dy, r_s2_ky_dx;
    logic signed [PW-1:0] n_s2_lx_dy, n_s2_ly_dx, n_s2_kx_ly;
    logic signed [PW-1:0] n_s2_ky_lx, n_s2_kx_dy, n_s2_ky_dx;

    always_comb begin
        n_s2_lx_dy = PW'(r_s1_lx) * PW'(r_s1_dy);
        n_s2_ly_dx = PW'(r_s1_ly) * PW'(r_s1_dx);
        n_s2_kx_ly = PW'(r_s1_kx) * PW'(r_s1_ly);
        n_s2_ky_lx = PW'(r_s1_ky) * PW'(r_s1_lx);
        n_s2_kx_dy = PW'(r_s1_kx) * PW'(r_s1_dy);
        n_s2_ky_dx = PW'(r_s1_ky) * PW'(r_s1_dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_ax    <= r_s1_ax;
            r_s2_ay    <= r_s1_ay;
            r_s2_dx    <= r_s1_dx;
            r_s2_dy    <= r_s1_dy;
            r_s2_lx_dy <= n_s2_lx_dy;
            r_s2_ly_dx <= n_s2_ly_dx;
            r_s2_kx_ly <= n_s2_kx_ly;
            r_s2_ky_lx <= n_s2_ky_lx;
            r_s2_kx_dy <= n_s2_kx_dy;
            r_s2_ky_dx <= n_s2_ky_dx;
        end
    end

    // stage 3: denominator and the two numerators
    logic                 r_s3_valid;
    logic signed [W-1:0]  r_s3_ax, r_s3_ay;
    logic signed [DW-1:0] r_s3_dx, r_s3_dy;
    logic signed [CW-1:0] r_s3_den, r_s3_ns, r_s3_nt;
    logic signed [CW-1:0] n_s3_den, n_s3_ns, n_s3_nt;

    always_comb begin
        n_s3_den = CW'(r_s2_lx_dy) - CW'(r_s2_ly_dx);
        n_s3_ns  = CW'(r_s2_kx_ly) - CW'(r_s2_ky_lx);
        n_s3_nt  = CW'(r_s2_kx_dy) - CW'(r_s2_ky_dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_ax  <= r_s2_ax;
            r_s3_ay  <= r_s2_ay;
            r_s3_dx  <= r_s2_dx;
            r_s3_dy  <= r_s2_dy;
            r_s3_den <= n_s3_den;
            r_s3_ns  <= n_s3_ns;
            r_s3_nt  <= n_s3_nt;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_ax    = r_s3_ax;
    assign o_ay    = r_s3_ay;
    assign o_dx    = r_s3_dx;
    assign o_dy    = r_s3_dy;
    assign o_den   = r_s3_den;
    assign o_ns    = r_s3_ns;
    assign o_nt    = r_s3_nt;

endmodule

// File: hw/rtl/sgi_classify.sv
module sgi_classify
    import sgi_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [THR_WIDTH-1:0]   i_threshold,
    input  logic                   i_valid,
    input  logic signed [W-1:0]    i_ax,
    input  logic signed [W-1:0]    i_ay,
    input  logic signed [W:0]      i_dx,
    input  logic signed [W:0]      i_dy,
    input  logic signed [2*W+2:0]  i_den,
    input  logic signed [2*W+2:0]  i_ns,
    input  logic signed [2*W+2:0]  i_nt,
    output logic                   o_valid,
    output logic                   o_hit,
    output logic signed [W-1:0]    o_ax,
    output logic signed [W-1:0]    o_ay,
    output logic                   o_sx,
    output logic                   o_sy,
    output logic [2*W:0]           o_den,
    output logic [3*W:0]           o_mx,
    output logic [3*W:0]           o_my
);

    localparam int CW = 2 * W + 3;
    localparam int NW = 2 * W + 1;
    localparam int RW = 3 * W + 1;
    localparam int MW = (CW > THR_WIDTH) ? CW : THR_WIDTH;

    // stage 4: parallel test, sign normalization, parameter range checks
    logic                 den_neg;
    logic signed [CW-1:0] den_abs, ns_norm, nt_norm;
    logic signed [W:0]    dx_abs, dy_abs;
    logic                 not_parallel, s_in_range, t_in_range, n_s4_hit;

    always_comb begin
        den_neg      = i_den[CW-1];
        den_abs      = den_neg ? -i_den : i_den;
        ns_norm      = den_neg ? -i_ns : i_ns;
        nt_norm      = den_neg ? -i_nt : i_nt;
        not_parallel = MW'($unsigned(den_abs)) > MW'(i_threshold);
        s_in_range   = !ns_norm[CW-1] && (ns_norm <= den_abs);
        t_in_range   = !nt_norm[CW-1] && (nt_norm <= den_abs);
        n_s4_hit     = not_parallel && s_in_range && t_in_range;
        dx_abs       = i_dx[W] ? -i_dx : i_dx;
        dy_abs       = i_dy[W] ? -i_dy : i_dy;
    end

    logic                r_s4_valid, r_s4_hit, r_s4_sx, r_s4_sy;
    logic signed [W-1:0] r_s4_ax, r_s4_ay;
    logic [W-1:0]        r_s4_dxm, r_s4_dym;
    logic [NW-1:0]       r_s4_den, r_s4_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_hit <= n_s4_hit;
            r_s4_ax  <= i_ax;
            r_s4_ay  <= i_ay;
            r_s4_sx  <= i_dx[W];
            r_s4_sy  <= i_dy[W];
            r_s4_dxm <= dx_abs[W-1:0];
            r_s4_dym <= dy_abs[W-1:0];
            r_s4_den <= den_abs[NW-1:0];
            r_s4_ns  <= ns_norm[NW-1:0];
        end
    end

    // stage 5: dividend magnitudes |d| * ns
    logic                r_s5_valid, r_s5_hit, r_s5_sx, r_s5_sy;
    logic signed [W-1:0] r_s5_ax, r_s5_ay;
    logic [NW-1:0]       r_s5_den;
    logic [RW-1:0]       r_s5_mx, r_s5_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_hit <= r_s4_hit;
            r_s5_ax  <= r_s4_ax;
            r_s5_ay  <= r_s4_ay;
            r_s5_sx  <= r_s4_sx;
            r_s5_sy  <= r_s4_sy;
            r_s5_den <= r_s4_den;
            r_s5_mx  <= RW'(r_s4_dxm) * RW'(r_s4_ns);
            r_s5_my  <= RW'(r_s4_dym) * RW'(r_s4_ns);
        end
    end

    assign o_valid = r_s5_valid;
    assign o_hit   = r_s5_hit;
    assign o_ax    = r_s5_ax;
    assign o_ay    = r_s5_ay;
    assign o_sx    = r_s5_sx;
    assign o_sy    = r_s5_sy;
    assign o_den   = r_s5_den;
    assign o_mx    = r_s5_mx;
    assign o_my    = r_s5_my;

endmodule

// File: hw/rtl/sgi_div.sv
module sgi_div #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_hit,
    input  logic signed [W-1:0] i_ax,
    input  logic signed [W-1:0] i_ay,
    input  logic                i_sx,
    input  logic                i_sy,
    input  logic [2*W:0]        i_den,
    input  logic [3*W:0]        i_mx,
    input  logic [3*W:0]        i_my,
    output logic                o_valid,
    output logic                o_hit,
    output logic signed [W-1:0] o_ax,
    output logic signed [W-1:0] o_ay,
    output logic                o_sx,
    output logic                o_sy,
    output logic [W-1:0]        o_qx,
    output logic [W-1:0]        o_qy
);

    localparam int QW = W;
    localparam int NW = 2 * W + 1;
    localparam int RW = 3 * W + 1;

    // one restoring step per stage, both axes side by side, msb first
    logic                r_valid [QW];
    logic                r_hit   [QW];
    logic signed [W-1:0] r_ax    [QW];
    logic signed [W-1:0] r_ay    [QW];
    logic                r_sx    [QW];
    logic                r_sy    [QW];
    logic [NW-1:0]       r_den   [QW];
    logic [RW-1:0]       r_rx    [QW];
    logic [RW-1:0]       r_ry    [QW];
    logic [QW-1:0]       r_qx    [QW];
    logic [QW-1:0]       r_qy    [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;

        logic                v_in, hit_in, sx_in, sy_in;
        logic signed [W-1:0] ax_in, ay_in;
        logic [NW-1:0]       den_in;
        logic [RW-1:0]       rx_in, ry_in;
        logic [QW-1:0]       qx_in, qy_in;
        logic [RW-1:0]       trial;
        logic                ge_x, ge_y;
        logic [RW-1:0]       n_rx, n_ry;
        logic [QW-1:0]       n_qx, n_qy;

        // stage input: module ports or the previous stage
        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign hit_in = i_hit;
            assign ax_in  = i_ax;
            assign ay_in  = i_ay;
            assign sx_in  = i_sx;
            assign sy_in  = i_sy;
            assign den_in = i_den;
            assign rx_in  = i_mx;
            assign ry_in  = i_my;
            assign qx_in  = '0;
            assign qy_in  = '0;
        end else begin : g_next
            assign v_in   = r_valid[k-1];
            assign hit_in = r_hit[k-1];
            assign ax_in  = r_ax[k-1];
            assign ay_in  = r_ay[k-1];
            assign sx_in  = r_sx[k-1];
            assign sy_in  = r_sy[k-1];
            assign den_in = r_den[k-1];
            assign rx_in  = r_rx[k-1];
            assign ry_in  = r_ry[k-1];
            assign qx_in  = r_qx[k-1];
            assign qy_in  = r_qy[k-1];
        end

        // compare against the shifted divisor and subtract
        always_comb begin
            trial   = RW'(den_in) << B;
            ge_x    = rx_in >= trial;
            ge_y    = ry_in >= trial;
            n_rx    = ge_x ? rx_in - trial : rx_in;
            n_ry    = ge_y ? ry_in - trial : ry_in;
            n_qx    = qx_in;
            n_qy    = qy_in;
            n_qx[B] = ge_x;
            n_qy[B] = ge_y;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hit[k] <= hit_in;
                r_ax[k]  <= ax_in;
                r_ay[k]  <= ay_in;
                r_sx[k]  <= sx_in;
                r_sy[k]  <= sy_in;
                r_den[k] <= den_in;
                r_rx[k]  <= n_rx;
                r_ry[k]  <= n_ry;
                r_qx[k]  <= n_qx;
                r_qy[k]  <= n_qy;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_hit   = r_hit[QW-1];
    assign o_ax    = r_ax[QW-1];
    assign o_ay    = r_ay[QW-1];
    assign o_sx    = r_sx[QW-1];
    assign o_sy    = r_sy[QW-1];
    assign o_qx    = r_qx[QW-1];
    assign o_qy    = r_qy[QW-1];

endmodule
